### design/gst_pkg.sv
// shared types and codes for the generational slot table
package gst_pkg;

  localparam int KIND_W   = 3;
  localparam int HIDX_W   = 16;
  localparam int GEN_W    = 32;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;
  localparam int OIDX_W   = 6;
  localparam int COLL_W   = 7;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [GEN_W-1:0]    gen_t;

  localparam kind_t KIND_PUBLISH = 3'd0;
  localparam kind_t KIND_REPLACE = 3'd1;
  localparam kind_t KIND_RETIRE  = 3'd2;
  localparam kind_t KIND_RESOLVE = 3'd3;
  localparam kind_t KIND_COLLECT = 3'd4;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_STALE     = 2'd1;
  localparam status_t STATUS_EXHAUSTED = 2'd2;
  localparam status_t STATUS_LIST_FULL = 2'd3;

  localparam gen_t GEN_RESET = 32'd1;

  // next generation, skipping zero
  function automatic gen_t gen_bump(input gen_t g);
    gen_t n;
    n = g + GEN_RESET;
    return (n == '0) ? GEN_RESET : n;
  endfunction

endpackage

### design/gst_if.sv
// request and response channel interfaces
interface gst_req_if;
  import gst_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  logic [HIDX_W-1:0] handle_index;
  gen_t  handle_generation;
  logic [VAL_W-1:0] fence_value;
  modport source(output valid, kind, handle_index, handle_generation, fence_value,
                 input ready);
  modport sink(input valid, kind, handle_index, handle_generation, fence_value,
               output ready);
endinterface

interface gst_rsp_if;
  import gst_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  logic [OIDX_W-1:0] slot_idx;
  gen_t    generation;
  logic [COLL_W-1:0] collected_count;
  modport source(output valid, status, slot_idx, generation, collected_count,
                 input ready);
  modport sink(input valid, status, slot_idx, generation, collected_count,
               output ready);
endinterface

### design/gst_ram.sv
// generic simple dual port ram with registered read
module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/gst_free_find.sv
// lowest free slot priority encoder
module gst_free_find #(
  parameter int SLOTS = 64
) (
  input  logic [SLOTS-1:0]                          free_vec,
  output logic                                      found,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] index
);
  localparam int SIDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found = 1'b1;
        index = SIDX_W'(i);
      end
    end
  end
endmodule

### design/generational_slot_table_unit.sv
// generational slot table: allocator with generation-checked handles and deferred free
//
// one request is worked at a time. for publish, replace, retire, resolve and unknown
// kinds the steps after acceptance are, in order: read the handle's generation
// from the generation ram, read the lowest free slot's generation, apply the
// operation and load the result register. the input is ready again once the
// result is loaded, and no new request is taken before then. collect replaces the
// apply step's exit with a walk over the retirement list ram: one read per entry,
// a wait on the last read's data and a closing step, then the result register is
// loaded. the retirement list is compacted in place during the walk. generations
// live in a ram whose entries read as 1 until first written (a valid flop per
// slot); slot states are flops. a new request is taken while the previous result
// still waits on the output register; a result that is not taken holds the unit
// in its last step until the output register frees.
module generational_slot_table_unit
  import gst_pkg::*;
#(
  parameter int SLOTS        = 64,
  parameter int RETIRE_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  gst_req_if.sink   in_ch,
  gst_rsp_if.source out_ch
);

  localparam int SIDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int RIDX_W = RETIRE_DEPTH > 1 ? $clog2(RETIRE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RETIRE_DEPTH + 1);
  localparam int RET_W  = VAL_W + SIDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_H, S_CHK, S_EXEC, S_COL, S_DONE
  } state_t;

  state_t state_r;

  // latched request
  kind_t             kind_r;
  logic [HIDX_W-1:0] hidx_full_r;
  gen_t              hgen_in_r;
  logic [VAL_W-1:0]  val_r;

  // slot state flops: retired is neither free nor live
  logic [SLOTS-1:0] free_r;
  logic [SLOTS-1:0] live_r;
  logic [SLOTS-1:0] gvalid_r;

  logic [CNT_W-1:0] rcnt_r;
  logic [CNT_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] wr_ptr_r;
  logic [CNT_W-1:0] coll_r;
  logic             pend_r;

  gen_t hgen_r;
  logic hlive_r;

  // result staging and output register
  status_t           res_status_r;
  logic [OIDX_W-1:0] res_idx_r;
  gen_t              res_gen_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [OIDX_W-1:0] out_idx_r;
  gen_t              out_gen_r;
  logic [COLL_W-1:0] out_coll_r;

  logic [SIDX_W-1:0] hidx;
  logic              hidx_ok;
  assign hidx    = hidx_full_r[SIDX_W-1:0];
  assign hidx_ok = 32'(hidx_full_r) < 32'(SLOTS);

  // lowest free slot
  logic              free_found;
  logic [SIDX_W-1:0] free_idx;
  gst_free_find #(.SLOTS(SLOTS)) u_find (
    .free_vec(free_r),
    .found   (free_found),
    .index   (free_idx)
  );

  // generation ram
  logic              gen_we;
  logic [SIDX_W-1:0] gen_raddr;
  gen_t              gen_rdata;
  gen_t              gen_eff;
  assign gen_raddr = (state_r == S_RD_H) ? hidx : free_idx;

  gst_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk  (clk),
    .we   (gen_we),
    .waddr(hidx),
    .wdata(gen_bump(hgen_r)),
    .raddr(gen_raddr),
    .rdata(gen_rdata)
  );

  // retirement list ram: {fence value, slot}
  logic              ret_we;
  logic [RIDX_W-1:0] ret_waddr;
  logic [RET_W-1:0]  ret_wdata;
  logic [RET_W-1:0]  ret_rdata;
  logic [VAL_W-1:0]  ret_val;
  logic [SIDX_W-1:0] ret_slot;
  assign ret_val  = ret_rdata[RET_W-1:SIDX_W];
  assign ret_slot = ret_rdata[SIDX_W-1:0];

  gst_ram #(.WIDTH(RET_W), .DEPTH(RETIRE_DEPTH)) u_ret_ram (
    .clk  (clk),
    .we   (ret_we),
    .waddr(ret_waddr),
    .wdata(ret_wdata),
    .raddr(rd_ptr_r[RIDX_W-1:0]),
    .rdata(ret_rdata)
  );

  // operation decode in the execute cycle
  logic list_full;
  logic do_retire;
  logic do_publish;
  assign list_full = rcnt_r >= CNT_W'(RETIRE_DEPTH);

  always_comb begin
    do_retire  = 1'b0;
    do_publish = 1'b0;
    if (state_r == S_EXEC) begin
      unique case (kind_r)
        KIND_PUBLISH: do_publish = free_found;
        KIND_REPLACE: begin
          do_publish = hlive_r && !list_full && free_found;
          do_retire  = do_publish;
        end
        KIND_RETIRE:  do_retire = hlive_r && !list_full;
        default:      ;
      endcase
    end
  end

  logic keep_entry;
  assign keep_entry = (state_r == S_COL) && pend_r && (ret_val > val_r);

  assign gen_we    = do_retire;
  assign gen_eff   = gvalid_r[free_idx] ? gen_rdata : GEN_RESET;
  assign ret_we    = do_retire || keep_entry;
  assign ret_waddr = do_retire ? rcnt_r[RIDX_W-1:0] : wr_ptr_r[RIDX_W-1:0];
  assign ret_wdata = do_retire ? {val_r, hidx} : ret_rdata;

  logic out_free;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '1;
      live_r      <= '0;
      gvalid_r    <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      // the done step reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r       <= in_ch.kind;
            hidx_full_r  <= in_ch.handle_index;
            hgen_in_r    <= in_ch.handle_generation;
            val_r        <= in_ch.fence_value;
            state_r      <= S_RD_H;
          end
        end
        S_RD_H: state_r <= S_CHK;
        S_CHK: begin
          // handle's generation is on the read port now
          hgen_r  <= gvalid_r[hidx] ? gen_rdata : GEN_RESET;
          hlive_r <= hidx_ok && live_r[hidx] &&
                     ((gvalid_r[hidx] ? gen_rdata : GEN_RESET) == hgen_in_r);
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          res_status_r <= STATUS_OK;
          res_idx_r    <= '0;
          res_gen_r    <= '0;
          coll_r       <= '0;
          state_r      <= S_DONE;
          unique case (kind_r)
            KIND_PUBLISH: begin
              if (!free_found) res_status_r <= STATUS_EXHAUSTED;
            end
            KIND_REPLACE, KIND_RETIRE: begin
              // stale first, then list full, then no free slot
              if (!hlive_r) res_status_r <= STATUS_STALE;
              else if (list_full) res_status_r <= STATUS_LIST_FULL;
              else if (kind_r == KIND_REPLACE && !free_found) begin
                res_status_r <= STATUS_EXHAUSTED;
              end
            end
            KIND_RESOLVE: begin
              if (!hlive_r) res_status_r <= STATUS_STALE;
              else res_idx_r <= OIDX_W'(hidx_full_r);
            end
            KIND_COLLECT: begin
              rd_ptr_r <= '0;
              wr_ptr_r <= '0;
              pend_r   <= 1'b0;
              state_r  <= S_COL;
            end
            default: ;
          endcase
          if (do_publish) begin
            free_r[free_idx] <= 1'b0;
            live_r[free_idx] <= 1'b1;
            res_idx_r        <= OIDX_W'(free_idx);
            res_gen_r        <= gen_eff;
          end
          if (do_retire) begin
            live_r[hidx]   <= 1'b0;
            gvalid_r[hidx] <= 1'b1;
            rcnt_r         <= rcnt_r + CNT_W'(1);
          end
        end
        S_COL: begin
          // issue one read per cycle, resolve the entry read last cycle
          if (rd_ptr_r < rcnt_r) begin
            rd_ptr_r <= rd_ptr_r + CNT_W'(1);
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (keep_entry) begin
              wr_ptr_r <= wr_ptr_r + CNT_W'(1);
            end else begin
              free_r[ret_slot] <= 1'b1;
              coll_r           <= coll_r + CNT_W'(1);
            end
          end
          if (!pend_r && rd_ptr_r >= rcnt_r) begin
            rcnt_r  <= wr_ptr_r;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_r;
            out_gen_r    <= res_gen_r;
            out_coll_r   <= COLL_W'(coll_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.slot_idx        = out_idx_r;
  assign out_ch.generation      = out_gen_r;
  assign out_ch.collected_count = out_coll_r;

  // a slot is never both free and live
  a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r & live_r) == '0) else $error("slot free and live at once");

  // list fill never passes its depth
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CNT_W'(RETIRE_DEPTH)) else $error("retirement list overflow");

  // compaction write pointer never overtakes the read pointer
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COL |-> wr_ptr_r <= rd_ptr_r) else $error("compaction overrun");

endmodule
